FILE: hw/rtl/pid_controller_filtered_derivative_top_defines.svh
// ---------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_TOP_DEFINES_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pid check failed");
`define PID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pid check failed");
`else
`define PID_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PID_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/pidfd_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Shared types and constants of the filtered-derivative PID block.
// ---------------------------------------------------------------------------
package pidfd_pkg;

  localparam int unsigned DtDefault = 655;
  localparam int unsigned AlphaOne  = 65536;

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_SETPT   = 3'd3,
    REG_INT_UP  = 3'd4,
    REG_INT_LO  = 3'd5,
    REG_ALPHA   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INC,
    ST_INT,
    ST_DIVST,
    ST_DIV,
    ST_RAW,
    ST_FA,
    ST_FB,
    ST_FSUM,
    ST_P,
    ST_I,
    ST_D,
    ST_SUM,
    ST_OUT
  } state_t;

  // multiply request to the serial multiplier
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic        [24:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

endpackage

FILE: hw/rtl/pidfd_mul.sv
// ---------------------------------------------------------------------------
// PID serial multiplier
// Signed by unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module pidfd_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  pidfd_pkg::mul_req_t req,
  output pidfd_pkg::mul_rsp_t rsp
);
  import pidfd_pkg::*;

  localparam int unsigned BW = 25;

  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] mcand_r, mcand_nxt;
  logic        [BW-1:0] mplier_r, mplier_nxt;
  logic        [4:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = req.a;
      mplier_nxt = req.b;
      cnt_nxt    = 5'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // add when the low bit is set, then shift one digit
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: hw/rtl/pidfd_div.sv
// ---------------------------------------------------------------------------
// PID serial divider
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// ---------------------------------------------------------------------------
module pidfd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [49:0] dividend,
  input  logic        [15:0] divisor,
  output logic               done,
  output logic signed [49:0] quotient
);
  import pidfd_pkg::*;

  localparam int unsigned NW = 50;

  logic [NW-1:0] q_r, q_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [15:0]   dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [17:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NW-1]} - {2'b00, dvs_r};
    if (start) begin
      neg_nxt  = dividend[NW-1];
      q_nxt    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

FILE: hw/rtl/pid_controller_filtered_derivative_top.sv
// ---------------------------------------------------------------------------
// PID controller with filtered derivative
// Trapezoidal integral, low-pass filtered slope, saturated Q16.16 drive.
// ---------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)         | tuser
//  in_     | slave     | measured[31:0], dt[47:32]  | -
//  out_    | master    | drive[31:0]                | drive_saturated
//  cfg_    | write     | index 3 bit, data 32 bit   | -
//
// The time per word is set by a 50-bit bit-serial divider (slope) and six
// passes through a shared 25-bit serial multiplier.
// The block holds one word at a time; in_tready is low until the result
// is loaded into the output register. A stalled result holds in out_tdata
// while the next word is already accepted and worked on.
// Reset clears control state, the integrator, slope and error history.
// ---------------------------------------------------------------------------
`include "pid_controller_filtered_derivative_top_defines.svh"

module pid_controller_filtered_derivative_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // measured[31:0], step_time[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive[31:0]
  output logic        out_tuser,  // drive_saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pidfd_pkg::*;

  // configuration
  logic [23:0]        gain_p_r, gain_i_r, gain_d_r;
  logic signed [31:0] setpt_r, int_up_r, int_lo_r;
  logic [16:0]        alpha_r;

  // controller state
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [32:0] last_err_r, last_err_nxt;
  logic signed [39:0] slope_r, slope_nxt;

  // per-word work registers
  state_t             st_r, st_nxt;
  logic signed [31:0] meas_r;
  logic [15:0]        dt_r;
  logic signed [32:0] err_r, err_nxt;
  logic signed [63:0] tmp_r, tmp_nxt;
  logic signed [39:0] raw_r, raw_nxt;
  logic signed [49:0] acc_r, acc_nxt;
  logic               out_pend_r, out_pend_nxt;
  logic               out_vld_r;
  logic [31:0]        out_data_r;
  logic               out_sat_r;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;
  logic               dstart;
  logic signed [49:0] ddvd;
  logic               ddone;
  logic signed [49:0] dquo;
  logic [16:0]        alpha_eff;
  logic signed [33:0] integ_sum;
  logic signed [33:0] err_dif;

  pidfd_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  pidfd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddvd),
    .divisor(dt_r), .done(ddone), .quotient(dquo)
  );

  assign in_tready  = (st_r == ST_IDLE) && !out_pend_r;
  assign alpha_eff  = alpha_r[16] ? 17'(AlphaOne) : alpha_r;
  assign err_dif    = 34'(err_r) - 34'(last_err_r);
  assign ddvd       = {err_dif, 16'b0};
  // floor of the trapezoid product by 2^17 fits 34 signed bits
  assign integ_sum  = 34'(integ_r) + $signed(tmp_r[50:17]);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_tvalid && in_tready) st_nxt = ST_ERR;
      ST_ERR:   st_nxt = ST_INC;
      ST_INC:   if (mrsp.done) st_nxt = ST_INT;
      ST_INT:   st_nxt = ST_DIVST;
      ST_DIVST: st_nxt = ST_DIV;
      ST_DIV:   if (ddone) st_nxt = ST_RAW;
      ST_RAW:   st_nxt = ST_FA;
      ST_FA:    if (mrsp.done) st_nxt = ST_FB;
      ST_FB:    if (mrsp.done) st_nxt = ST_FSUM;
      ST_FSUM:  st_nxt = ST_P;
      ST_P:     if (mrsp.done) st_nxt = ST_I;
      ST_I:     if (mrsp.done) st_nxt = ST_D;
      ST_D:     if (mrsp.done) st_nxt = ST_SUM;
      ST_SUM:   st_nxt = ST_OUT;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // datapath and multiplier control
  always_comb begin
    err_nxt      = err_r;
    tmp_nxt      = tmp_r;
    raw_nxt      = raw_r;
    acc_nxt      = acc_r;
    integ_nxt    = integ_r;
    last_err_nxt = last_err_r;
    slope_nxt    = slope_r;
    out_pend_nxt = out_pend_r;
    mreq.start   = 1'b0;
    mreq.a       = '0;
    mreq.b       = '0;
    dstart       = 1'b0;
    case (st_r)
      ST_ERR: begin
        err_nxt    = 33'(setpt_r) - 33'(meas_r);
        mreq.start = 1'b1;
        mreq.a     = 64'(34'(33'(setpt_r) - 33'(meas_r)) + 34'(last_err_r));
        mreq.b     = 25'(dt_r);
      end
      ST_INC: if (mrsp.done) tmp_nxt = mrsp.prod;
      ST_INT: begin
        // clamp, upper test first
        if (integ_sum > 34'(int_up_r)) begin
          integ_nxt = int_up_r;
        end else if (integ_sum < 34'(int_lo_r)) begin
          integ_nxt = int_lo_r;
        end else begin
          integ_nxt = integ_sum[31:0];
        end
      end
      ST_DIVST: dstart = 1'b1;
      ST_RAW: begin
        if (dquo > 50'sh7F_FFFF_FFFF) begin
          raw_nxt = 40'sh7F_FFFF_FFFF;
        end else if (dquo < -50'sh80_0000_0000) begin
          raw_nxt = 40'sh80_0000_0000;
        end else begin
          raw_nxt = dquo[39:0];
        end
        mreq.start = 1'b1;
        mreq.a     = 64'(raw_nxt);
        mreq.b     = 25'(alpha_eff);
        last_err_nxt = err_r;
      end
      ST_FA: if (mrsp.done) begin
        acc_nxt    = '0;
        tmp_nxt    = mrsp.prod;
        mreq.start = 1'b1;
        mreq.a     = 64'(slope_r);
        mreq.b     = 25'(17'(AlphaOne) - alpha_eff);
      end
      ST_FB: if (mrsp.done) tmp_nxt = tmp_r + mrsp.prod;
      ST_FSUM: begin
        slope_nxt  = tmp_r[55:16];
        mreq.start = 1'b1;
        mreq.a     = 64'(err_r);
        mreq.b     = 25'(gain_p_r);
      end
      ST_P: if (mrsp.done) begin
        acc_nxt    = 50'($signed(mrsp.prod[63:16]));
        mreq.start = 1'b1;
        mreq.a     = 64'(integ_r);
        mreq.b     = 25'(gain_i_r);
      end
      ST_I: if (mrsp.done) begin
        acc_nxt    = acc_r + 50'($signed(mrsp.prod[63:16]));
        mreq.start = 1'b1;
        mreq.a     = 64'(slope_r);
        mreq.b     = 25'(gain_d_r);
      end
      ST_D: if (mrsp.done) acc_nxt = acc_r + 50'($signed(mrsp.prod[63:16]));
      ST_OUT: out_pend_nxt = 1'b1;
      default: ;
    endcase
    // drain the pending result into the output register
    if (out_pend_r && (!out_vld_r || out_tready)) out_pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      out_pend_r <= 1'b0;
      out_vld_r  <= 1'b0;
      integ_r    <= '0;
      last_err_r <= '0;
      slope_r    <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      setpt_r    <= '0;
      int_up_r   <= 32'sd6553600;
      int_lo_r   <= -32'sd6553600;
      alpha_r    <= 17'd32768;
    end else begin
      st_r       <= st_nxt;
      out_pend_r <= out_pend_nxt;
      integ_r    <= integ_nxt;
      last_err_r <= last_err_nxt;
      slope_r    <= slope_nxt;
      if (out_pend_r && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P: gain_p_r <= cfg_data[23:0];
          REG_GAIN_I: gain_i_r <= cfg_data[23:0];
          REG_GAIN_D: gain_d_r <= cfg_data[23:0];
          REG_SETPT:  setpt_r  <= cfg_data;
          REG_INT_UP: int_up_r <= cfg_data;
          REG_INT_LO: int_lo_r <= cfg_data;
          REG_ALPHA:  alpha_r  <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      meas_r <= in_tdata[31:0];
      dt_r   <= (in_tdata[47:32] == 16'd0) ? 16'(DtDefault) : in_tdata[47:32];
    end
    err_r <= err_nxt;
    tmp_r <= tmp_nxt;
    raw_r <= raw_nxt;
    acc_r <= acc_nxt;
    if (st_r == ST_SUM) begin
      // saturate the drive to 32 bits
      if (acc_r > 50'sh7FFF_FFFF) begin
        out_data_r <= 32'h7FFF_FFFF;
        out_sat_r  <= 1'b1;
      end else if (acc_r < -50'sh8000_0000) begin
        out_data_r <= 32'h8000_0000;
        out_sat_r  <= 1'b1;
      end else begin
        out_data_r <= acc_r[31:0];
        out_sat_r  <= 1'b0;
      end
    end
  end

  logic [31:0] odata_r;
  logic        osat_r;
  always_ff @(posedge clk) begin
    if (out_pend_r && (!out_vld_r || out_tready)) begin
      odata_r <= out_data_r;
      osat_r  <= out_sat_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = osat_r;

  `PID_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, st_r == ST_IDLE)
  `PID_ASSERT_NXT(a_accept_runs, clk, rst_n, in_tvalid && in_tready, st_r == ST_ERR)
  `PID_ASSERT_IMP(a_sat_bound, clk, rst_n, out_tvalid && out_tuser,
    out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000)

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// PID controller testbench
// Drives measured/step-time words with random idling and output stalls,
// predicts each drive value from a bit-accurate model of the controller and
// compares it, field by field, with what the block delivers.
// ---------------------------------------------------------------------------
module testbench;
  import pidfd_pkg::*;

  typedef struct {
    logic [31:0] drive;
    logic        clipped;
  } drive_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of configuration and state
  longint kp, ki, kd, target, int_hi, int_lo, alpha_reg;
  longint integ, prev_err, slope;

  drive_word_t expected_drives[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;

  pid_controller_filtered_derivative_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // floor division by 2^s; >>> on a longint is arithmetic
  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the controller state by one word and return the expected drive.
  function automatic drive_word_t compute_drive(logic [31:0] meas, logic [15:0] step);
    longint      dt, err, sum, raw, a, p, i, d, total;
    drive_word_t res;
    dt  = (step == 16'd0) ? longint'(DtDefault) : longint'(step);
    err = target - longint'(signed'(meas));
    sum = integ + floor_div_pow2((err + prev_err) * dt, 17);
    // upper test first, so crossed clamps resolve as the block does
    if (sum > int_hi) sum = int_hi;
    else if (sum < int_lo) sum = int_lo;
    integ = sum;
    raw = ((err - prev_err) * 65536) / dt;  // truncates toward zero
    raw = clip(raw, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
    a = (alpha_reg > AlphaOne) ? longint'(AlphaOne) : alpha_reg;
    slope = floor_div_pow2(a * raw + (longint'(AlphaOne) - a) * slope, 16);
    prev_err = err;
    p = floor_div_pow2(kp * err, 16);
    i = floor_div_pow2(ki * integ, 16);
    d = floor_div_pow2(kd * slope, 16);
    total = p + i + d;
    res.clipped = (total > 64'sd2147483647) || (total < -64'sd2147483648);
    res.drive = 32'(clip(total, -64'sd2147483648, 64'sd2147483647));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = longint'(value[23:0]);
      REG_GAIN_I: ki = longint'(value[23:0]);
      REG_GAIN_D: kd = longint'(value[23:0]);
      REG_SETPT:  target = longint'(signed'(value));
      REG_INT_UP: int_hi = longint'(signed'(value));
      REG_INT_LO: int_lo = longint'(signed'(value));
      REG_ALPHA:  alpha_reg = longint'(value[16:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold valid until the word is taken, then predict it.
  // Valid stays high on return; the next idle gap or the drain drops it.
  task automatic send_word(logic [31:0] meas, logic [15:0] step);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {step, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_drives.push_back(compute_drive(meas, step));
  endtask

  // Wait until every result is back plus the block's drain time.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every delivered word with the oldest expectation.
  always @(posedge clk) begin
    drive_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 32'd0);
      end else begin
        want = expected_drives.pop_front();
        if (out_tdata !== want.drive) report_mismatch("drive", out_tdata, want.drive);
        if (out_tuser !== want.clipped)
          report_mismatch("drive_saturated", 32'(out_tuser), 32'(want.clipped));
      end
    end
  end

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20000)) - 10000) <<< 8;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(4000)) - 2000) <<< 12;
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 8));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_gains();
    write_reg(REG_GAIN_P, $urandom_range(3) == 0 ? $urandom() : $urandom_range(131072));
    write_reg(REG_GAIN_I, $urandom_range(3) == 0 ? $urandom() : $urandom_range(131072));
    write_reg(REG_GAIN_D, $urandom_range(3) == 0 ? $urandom() : $urandom_range(4096));
    write_reg(REG_SETPT, $urandom_range(1) ? $urandom() : 32'($urandom_range(65536 * 50)));
    write_reg(REG_INT_UP, $urandom_range(1) ? $urandom() : 32'd6553600);
    write_reg(REG_INT_LO, $urandom_range(1) ? $urandom() : -32'sd6553600);
    write_reg(REG_ALPHA, $urandom_range(131071));
  endtask

  // Extremes of the fields, zero step, full and over-one alpha, crossed clamps.
  task automatic test_directed();
    write_reg(REG_GAIN_P, 32'h0001_0000);
    write_reg(REG_GAIN_I, 32'h0000_8000);
    write_reg(REG_GAIN_D, 32'h0000_0100);
    send_word(32'h0000_0000, 16'd0);
    send_word(32'h7FFF_FFFF, 16'hFFFF);
    send_word(32'h8000_0000, 16'd1);
    send_word(32'h0001_0000, 16'd0);
    send_word(32'hFFFF_0000, 16'd655);
    drain();
    write_reg(REG_GAIN_P, 32'h00FF_FFFF);
    write_reg(REG_GAIN_I, 32'h00FF_FFFF);
    write_reg(REG_GAIN_D, 32'h00FF_FFFF);
    write_reg(REG_ALPHA, 32'h0001_0000);
    send_word(32'h8000_0000, 16'd1);
    send_word(32'h7FFF_FFFF, 16'd1);
    send_word(32'h0000_0000, 16'hFFFF);
    drain();
    write_reg(REG_ALPHA, 32'h0001_FFFF);     // alpha above one
    write_reg(REG_SETPT, 32'h7FFF_FFFF);
    write_reg(REG_INT_UP, 32'h8000_0000);    // crossed clamps
    write_reg(REG_INT_LO, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 16'd2);
    send_word(32'h1234_5678, 16'd0);
    send_word(32'h7FFF_FFFF, 16'hFFFF);
    drain();
    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_SETPT, 32'h8000_0000);
    write_reg(REG_INT_UP, 32'h7FFF_FFFF);
    write_reg(REG_INT_LO, 32'h8000_0000);
    write_reg(REG_GAIN_D, 32'd0);
    send_word(32'h7FFF_FFFF, 16'd3);
    send_word(32'h5555_5555, 16'hAAAA);
    send_word(32'hAAAA_AAAA, 16'h5555);
    drain();
  endtask

  // Random words under one idling pattern, fresh settings every phase.
  task automatic test_random(int words, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < words; k++) begin
      if (k % 60 == 0) begin
        drain();
        random_gains();
      end
      send_word(rand_meas(), rand_step());
    end
    drain();
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 1500;
    for (int k = 0; k < 8; k++) send_word(rand_meas(), rand_step());
    drain();
  endtask

  initial begin
    error_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_data  = '0;
    kp = 0; ki = 0; kd = 0; target = 0;
    int_hi = 6553600; int_lo = -6553600; alpha_reg = 32768;
    integ = 0; prev_err = 0; slope = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(180, 0, 0);
    test_random(170, 78, 0);
    test_random(170, 0, 78);
    test_random(160, 16, 16);
    test_backpressure();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: bounds a run of ~700 words with a wide margin.
  initial begin
    #(12 * 2000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
